/* rtl/lspt_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lspt_pkg: shared constants and types for the lattice sign-pattern tally
// Sizes of the ray, offset and entry tables, request codes, register indexes.
// ----------------------------------------------------------------------------
package lspt_pkg;
	localparam int DIM_MAX     = 4;
	localparam int RAYS_MAX    = 16;
	localparam int ENTRIES_MAX = 64;
	localparam int RAY_AW      = $clog2(RAYS_MAX);
	localparam int ENT_AW      = $clog2(ENTRIES_MAX);
	localparam int CNT_W       = $clog2(ENTRIES_MAX + 1);

	typedef logic [1:0] req_t;
	localparam req_t REQ_LOAD  = 2'd0;
	localparam req_t REQ_CLASS = 2'd1;
	localparam req_t REQ_READ  = 2'd2;
	localparam req_t REQ_CLEAR = 2'd3;

	typedef logic [2:0] reg_idx_t;
	localparam reg_idx_t REG_DIMS = 3'd0;
	localparam reg_idx_t REG_RAYS = 3'd1;
	localparam reg_idx_t REG_BND0 = 3'd2;
	localparam reg_idx_t REG_BND3 = 3'd5;
endpackage
`default_nettype wire

/* rtl/lspt_dot.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lspt_dot: ray test unit
// Multiplies the point by one ray, one coordinate a cycle, and compares the
// sum against minus the divisor offset. Ray data arrives from the ray memory.
// ----------------------------------------------------------------------------
module lspt_dot (
	input  wire  logic clk,
	input  wire  logic arst_n,
	input  wire  logic start,
	input  wire  logic [2:0] ndims,
	input  wire  logic [31:0] ray_word,
	input  wire  logic signed [15:0] ray_off,
	input  wire  logic signed [15:0] c0,
	input  wire  logic signed [15:0] c1,
	input  wire  logic signed [15:0] c2,
	input  wire  logic signed [15:0] c3,
	output logic done,
	output logic pass
);
	import lspt_pkg::*;

	logic busy_q;
	logic [2:0] d_q;
	logic signed [26:0] acc_q;
	logic signed [15:0] cx;
	logic signed [7:0] kx;
	logic signed [23:0] prod;
	logic signed [26:0] acc_n;

	// select coordinate and coefficient of this step
	always_comb begin
		unique case (d_q[1:0])
			2'd0: begin cx = c0; kx = ray_word[7:0]; end
			2'd1: begin cx = c1; kx = ray_word[15:8]; end
			2'd2: begin cx = c2; kx = ray_word[23:16]; end
			default: begin cx = c3; kx = ray_word[31:24]; end
		endcase
		prod = cx * kx;
		acc_n = acc_q + 27'(prod);
	end

	// iterate over the used coordinates
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			d_q <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				d_q <= '0;
			end else if (busy_q) begin
				d_q <= d_q + 3'd1;
				if (d_q + 3'd1 >= ndims) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) acc_q <= '0;
		else if (busy_q) acc_q <= acc_n;
		if (busy_q && d_q + 3'd1 >= ndims)
			pass <= (acc_n >= -27'(ray_off));
	end
endmodule
`default_nettype wire

/* rtl/lattice_sign_pattern_tally_top.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lattice_sign_pattern_tally_top: sign-pattern classifier and tally table
// Builds a pattern bit per ray, searches the entry memory, adds or counts.
// ----------------------------------------------------------------------------
//  channel | signals                         | direction
//  in      | in_valid, in_stall, fields      | word in
//  out     | out_valid, out_stall, fields    | word out
//  cfg     | cfg_we, cfg_index, cfg_data     | register write
// Load and clear answer in the cycle after acceptance, a read after ST_RDWT
// and ST_RDOUT. A classify runs ST_RAYRD, ST_RAYGO, ST_RAYWT per ray test, then
// ST_SRD and ST_SCMP per entry searched in the single-port pattern memory,
// then ST_UPD and ST_WB to update, ST_OUT to output; a full table skips them.
// Reset empties the table; memories keep undefined contents, no sweep.
// A stalled output holds its word; the next word is taken once it leaves.
module lattice_sign_pattern_tally_top (
	input  wire  logic clk,
	input  wire  logic arst_n,
	input  wire  logic in_valid,
	output logic in_stall,
	input  wire  logic [1:0] req_type,
	input  wire  logic [3:0] ray_index,
	input  wire  logic [5:0] entry_index,
	input  wire  logic signed [7:0] coef0,
	input  wire  logic signed [7:0] coef1,
	input  wire  logic signed [7:0] coef2,
	input  wire  logic signed [7:0] coef3,
	input  wire  logic signed [15:0] offset_value,
	input  wire  logic signed [15:0] coord0,
	input  wire  logic signed [15:0] coord1,
	input  wire  logic signed [15:0] coord2,
	input  wire  logic signed [15:0] coord3,
	output logic out_valid,
	input  wire  logic out_stall,
	output logic [5:0] hit_index,
	output logic hit_valid,
	output logic [15:0] pattern_bits,
	output logic [31:0] entry_points,
	output logic on_boundary,
	output logic table_full,
	output logic [6:0] entries_stored,
	output logic [31:0] points_seen,
	input  wire  logic cfg_we,
	input  wire  logic [2:0] cfg_index,
	input  wire  logic [31:0] cfg_data
);
	import lspt_pkg::*;

	localparam logic [3:0] ST_IDLE = 4'd0, ST_RAYRD = 4'd1, ST_RAYGO = 4'd2,
		ST_RAYWT = 4'd3, ST_SRD = 4'd4, ST_SCMP = 4'd5, ST_UPD = 4'd6,
		ST_WB = 4'd7, ST_OUT = 4'd8, ST_RDWT = 4'd9, ST_RDOUT = 4'd10;

	// configuration registers
	logic [2:0] dims_q;
	logic [4:0] rays_q;
	logic [31:0] bnd_q [DIM_MAX];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dims_q <= 3'd4;
			rays_q <= 5'd16;
			for (int i = 0; i < DIM_MAX; i++) bnd_q[i] <= '0;
		end else if (cfg_we) begin
			if (cfg_index == REG_DIMS) dims_q <= cfg_data[2:0];
			else if (cfg_index == REG_RAYS) rays_q <= cfg_data[4:0];
			else if (cfg_index >= REG_BND0 && cfg_index <= REG_BND3)
				bnd_q[2'(cfg_index - REG_BND0)] <= cfg_data;
		end
	end

	logic [2:0] ndims;
	logic [4:0] nrays;
	assign ndims = (dims_q == 3'd0) ? 3'd1 : (dims_q > 3'd4) ? 3'd4 : dims_q;
	assign nrays = (rays_q == 5'd0) ? 5'd1 : (rays_q > 5'd16) ? 5'd16 : rays_q;

	// memories
	logic [31:0] ray_mem [RAYS_MAX];
	logic [15:0] off_mem [RAYS_MAX];
	logic [15:0] pat_mem [ENTRIES_MAX];
	logic [32:0] cnt_mem [ENTRIES_MAX];
	logic [31:0] ray_rd;
	logic [15:0] off_rd;
	logic [15:0] pat_rd;
	logic [32:0] cnt_rd;

	logic [3:0] st_q;
	logic [4:0] rj_q;
	logic [15:0] pat_q;
	logic [6:0] ei_q;
	logic [CNT_W-1:0] total_q;
	logic [31:0] ptot_q;
	logic bnd_hit_q;
	logic signed [15:0] c_q [DIM_MAX];
	logic [ENT_AW-1:0] addr;
	logic pat_we, cnt_we;
	logic [32:0] cnt_wd;
	logic in_acc, out_acc;
	logic dot_start;
	logic ddone, dpass;

	assign in_acc = in_valid && !in_stall;
	assign out_acc = out_valid && !out_stall;
	assign in_stall = (st_q != ST_IDLE) || out_valid;

	// ray memories: write on load, read one slot per test
	always_ff @(posedge clk) begin
		if (in_acc && req_type == REQ_LOAD) begin
			ray_mem[ray_index] <= {coef3, coef2, coef1, coef0};
			off_mem[ray_index] <= offset_value;
		end
		ray_rd <= ray_mem[rj_q[RAY_AW-1:0]];
		off_rd <= off_mem[rj_q[RAY_AW-1:0]];
	end

	lspt_dot u_dot (
		.clk(clk), .arst_n(arst_n), .start(dot_start), .ndims(ndims),
		.ray_word(ray_rd), .ray_off(off_rd),
		.c0(c_q[0]), .c1(c_q[1]), .c2(c_q[2]), .c3(c_q[3]),
		.done(ddone), .pass(dpass)
	);

	// entry memories, single address
	always_comb begin
		priority if (st_q == ST_IDLE) addr = entry_index;
		else addr = ei_q[ENT_AW-1:0];
	end
	always_ff @(posedge clk) begin
		if (pat_we) pat_mem[addr] <= pat_q;
		if (cnt_we) cnt_mem[addr] <= cnt_wd;
		pat_rd <= pat_mem[addr];
		cnt_rd <= cnt_mem[addr];
	end

	logic [31:0] cnt_inc;
	assign cnt_inc = (cnt_rd[31:0] == 32'hFFFF_FFFF) ? cnt_rd[31:0] : cnt_rd[31:0] + 32'd1;
	assign pat_we = (st_q == ST_UPD) && (ei_q == 7'(total_q));
	assign cnt_we = (st_q == ST_WB);
	always_ff @(posedge clk) cnt_wd <= ((ei_q == 7'(total_q)) ? 33'd1
		: {cnt_rd[32] | bnd_hit_q, cnt_inc}) | {bnd_hit_q, 32'd0};
	assign dot_start = (st_q == ST_RAYGO);

	// boundary check on the incoming point
	logic bnd_any;
	always_comb begin
		logic signed [15:0] cv [DIM_MAX];
		cv[0] = coord0; cv[1] = coord1; cv[2] = coord2; cv[3] = coord3;
		bnd_any = 1'b0;
		for (int d = 0; d < DIM_MAX; d++)
			if (3'(d) < ndims && (cv[d] == bnd_q[d][15:0] || cv[d] == bnd_q[d][31:16]))
				bnd_any = 1'b1;
	end

	// control sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			out_valid <= 1'b0;
			total_q <= '0;
			ptot_q <= '0;
		end else begin
			if (out_acc) out_valid <= 1'b0;
			unique case (st_q)
				ST_IDLE: if (in_acc) begin
					hit_index <= (req_type == REQ_READ) ? entry_index : '0;
					hit_valid <= 1'b0; pattern_bits <= '0;
					entry_points <= '0; on_boundary <= 1'b0; table_full <= 1'b0;
					unique case (req_type)
						REQ_LOAD: begin
							entries_stored <= 7'(total_q); points_seen <= ptot_q;
							out_valid <= 1'b1;
						end
						REQ_CLEAR: begin
							total_q <= '0; ptot_q <= '0;
							entries_stored <= '0; points_seen <= '0;
							out_valid <= 1'b1;
						end
						REQ_READ: begin
							// hold the read address while the data settles
							ei_q <= 7'(entry_index);
							st_q <= ST_RDWT;
						end
						default: begin
							c_q[0] <= coord0; c_q[1] <= coord1;
							c_q[2] <= coord2; c_q[3] <= coord3;
							bnd_hit_q <= bnd_any;
							ptot_q <= (ptot_q == 32'hFFFF_FFFF) ? ptot_q : ptot_q + 32'd1;
							rj_q <= '0; pat_q <= '0;
							st_q <= ST_RAYRD;
						end
					endcase
				end
				ST_RAYRD: st_q <= ST_RAYGO;
				ST_RAYGO: st_q <= ST_RAYWT;
				ST_RAYWT: if (ddone) begin
					pat_q[rj_q[RAY_AW-1:0]] <= dpass;
					rj_q <= rj_q + 5'd1;
					if (rj_q + 5'd1 >= nrays) begin
						ei_q <= '0; st_q <= ST_SRD;
					end else st_q <= ST_RAYRD;
				end
				ST_SRD: begin
					if (ei_q >= 7'(total_q)) begin
						if (total_q == CNT_W'(ENTRIES_MAX)) begin
							pattern_bits <= pat_q; table_full <= 1'b1;
							entries_stored <= 7'(total_q); points_seen <= ptot_q;
							out_valid <= 1'b1; st_q <= ST_IDLE;
						end else st_q <= ST_UPD;
					end else st_q <= ST_SCMP;
				end
				ST_SCMP: begin
					if (pat_rd == pat_q) st_q <= ST_UPD;
					else begin ei_q <= ei_q + 7'd1; st_q <= ST_SRD; end
				end
				ST_UPD: st_q <= ST_WB;
				ST_WB: begin
					if (ei_q == 7'(total_q)) total_q <= total_q + CNT_W'(1);
					st_q <= ST_OUT;
				end
				ST_OUT: begin
					hit_index <= ei_q[ENT_AW-1:0]; hit_valid <= 1'b1;
					pattern_bits <= pat_q; entry_points <= cnt_wd[31:0];
					on_boundary <= cnt_wd[32];
					entries_stored <= 7'(total_q); points_seen <= ptot_q;
					out_valid <= 1'b1; st_q <= ST_IDLE;
				end
				ST_RDWT: st_q <= ST_RDOUT;
				ST_RDOUT: begin
					if (7'(hit_index) < 7'(total_q)) begin
						hit_valid <= 1'b1; pattern_bits <= pat_rd;
						entry_points <= cnt_rd[31:0]; on_boundary <= cnt_rd[32];
					end
					entries_stored <= 7'(total_q); points_seen <= ptot_q;
					out_valid <= 1'b1; st_q <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// checks
	a_tot: assert property (@(posedge clk) disable iff (!arst_n)
		total_q <= CNT_W'(ENTRIES_MAX)) else $error("entry total overflow");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q != ST_IDLE) |-> !out_valid) else $error("output while busy");
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && table_full) |-> !hit_valid) else $error("full with hit");
endmodule
`default_nettype wire
